### hdl/dlec_pkg.sv
// package: microcode types, control labels and the sequencer program
`timescale 1ns / 1ps
package dlec_pkg;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_MUL_INIT_ONE,
		OP_MUL_INIT_CUR,
		OP_MUL_STEP,
		OP_INC_K,
		OP_SET_FOUND,
		OP_EMIT
	} op_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_INPUT,
		C_SMALL_MOD,
		C_BASE_HIT,
		C_CNT_NZ,
		C_K_END,
		C_TERM_HIT,
		C_OUT_BUSY
	} cond_t;

	localparam int PC_W = 4;
	typedef logic [PC_W-1:0] pc_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} uword_t;

	typedef struct packed {
		logic no_input;
		logic small_mod;
		logic base_hit;
		logic cnt_nz;
		logic k_end;
		logic term_hit;
		logic out_busy;
	} dp_flags_t;

	localparam pc_t PC_IDLE  = 4'd0;
	localparam pc_t PC_RED   = 4'd4;
	localparam pc_t PC_LOOP  = 4'd6;
	localparam pc_t PC_MUL   = 4'd7;
	localparam pc_t PC_HIT   = 4'd11;
	localparam pc_t PC_EMIT  = 4'd12;

	function automatic uword_t ucode(input pc_t pc);
		uword_t w;
		case (pc)
			4'd0:    w = '{op: OP_LOAD,         cond: C_NO_INPUT,  target: PC_IDLE};
			4'd1:    w = '{op: OP_NOP,          cond: C_SMALL_MOD, target: PC_EMIT};
			4'd2:    w = '{op: OP_NOP,          cond: C_BASE_HIT,  target: PC_HIT};
			4'd3:    w = '{op: OP_MUL_INIT_ONE, cond: C_NEVER,     target: PC_IDLE};
			4'd4:    w = '{op: OP_MUL_STEP,     cond: C_CNT_NZ,    target: PC_RED};
			4'd5:    w = '{op: OP_NOP,          cond: C_K_END,     target: PC_EMIT};
			4'd6:    w = '{op: OP_MUL_INIT_CUR, cond: C_NEVER,     target: PC_IDLE};
			4'd7:    w = '{op: OP_MUL_STEP,     cond: C_CNT_NZ,    target: PC_MUL};
			4'd8:    w = '{op: OP_INC_K,        cond: C_TERM_HIT,  target: PC_HIT};
			4'd9:    w = '{op: OP_NOP,          cond: C_K_END,     target: PC_EMIT};
			4'd10:   w = '{op: OP_NOP,          cond: C_ALWAYS,    target: PC_LOOP};
			4'd11:   w = '{op: OP_SET_FOUND,    cond: C_NEVER,     target: PC_IDLE};
			4'd12:   w = '{op: OP_EMIT,         cond: C_OUT_BUSY,  target: PC_EMIT};
			default: w = '{op: OP_NOP,          cond: C_ALWAYS,    target: PC_IDLE};
		endcase
		return w;
	endfunction

endpackage

### hdl/dlec_if.sv
// interfaces: operand and result channels
`timescale 1ns / 1ps
interface dlec_in_if #(
	parameter int VALUE_BITS = 16
) ();
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] modulus;
	logic [VALUE_BITS-1:0] base;
	logic [VALUE_BITS-1:0] target;

	modport source(output valid, output modulus, output base, output target, input ready);
	modport sink(input valid, input modulus, input base, input target, output ready);
endinterface

interface dlec_out_if ();
	logic valid;
	logic ready;
	logic found;

	modport source(output valid, output found, input ready);
	modport sink(input valid, input found, output ready);
endinterface

### hdl/discrete_log_existence_check_top.sv
// Discrete log existence check: operands in on one channel, a found flag out on the other.
// Each operand transaction carries modulus, base and target; each gives one result
// transaction whose found bit says whether base^k mod modulus equals target for some
// k in 1..modulus-1, the first power being the unreduced base.
// The search is run by a microcoded sequencer over a shift-and-add modular multiplier
// that consumes one multiplier bit per cycle.
// A modulus below two gives a result with found clear and no search; otherwise a base
// equal to the target is found at k = 1, and the search stops at the first matching
// exponent or, when none matches, after exponent modulus - 1.
// One operand transaction is worked on at a time; once the result has moved into the
// output register, the sequencer passes a spare program step back to idle and accepts
// the next one there, even while that result still waits.
// If the receiver stalls, the result is held in the output register and the sequencer
// waits until that register drains before loading a new result.
// Reset clears the sequencer to idle and empties the output register; no state is kept
// between transactions.
`timescale 1ns / 1ps
module discrete_log_existence_check_top
	import dlec_pkg::*;
#(
	parameter int VALUE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	dlec_in_if.sink     operands,
	dlec_out_if.source  result
);

	uword_t    uw;
	dp_flags_t flags;

	dlec_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.uw     (uw)
	);

	dlec_datapath #(
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.uw       (uw),
		.flags    (flags),
		.operands (operands),
		.result   (result)
	);

endmodule

### hdl/dlec_seq.sv
// microcode sequencer: step counter, program table and conditional jumps
`timescale 1ns / 1ps
module dlec_seq
	import dlec_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  dp_flags_t flags,
	output uword_t    uw
);

	pc_t  pc_q;
	pc_t  pc_next;
	logic take;

	assign uw = ucode(pc_q);

	always_comb begin
		case (uw.cond)
			C_NEVER:     take = 1'b0;
			C_ALWAYS:    take = 1'b1;
			C_NO_INPUT:  take = flags.no_input;
			C_SMALL_MOD: take = flags.small_mod;
			C_BASE_HIT:  take = flags.base_hit;
			C_CNT_NZ:    take = flags.cnt_nz;
			C_K_END:     take = flags.k_end;
			C_TERM_HIT:  take = flags.term_hit;
			C_OUT_BUSY:  take = flags.out_busy;
			default:     take = 1'b1;
		endcase
		pc_next = take ? uw.target : pc_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

### hdl/dlec_datapath.sv
// datapath: operand registers, shift-and-add modular multiplier, result register
`timescale 1ns / 1ps
module dlec_datapath
	import dlec_pkg::*;
#(
	parameter int VALUE_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  uword_t           uw,
	output dp_flags_t        flags,
	dlec_in_if.sink          operands,
	dlec_out_if.source       result
);

	localparam int N     = VALUE_BITS;
	localparam int CNT_W = $clog2(VALUE_BITS);

	logic [N-1:0]     m_q;
	logic [N-1:0]     a_q;
	logic [N-1:0]     b_q;
	logic [N-1:0]     y_q;
	logic [N-1:0]     r_q;
	logic [N-1:0]     k_q;
	logic [CNT_W-1:0] cnt_q;
	logic             found_q;
	logic             out_valid_q;
	logic             out_found_q;

	logic [N+1:0] sum;
	logic [N+1:0] m1;
	logic [N+1:0] m2;
	logic [N+1:0] sub1;
	logic [N+1:0] sub2;
	logic [N-1:0] r_step;

	// r <- 2r + bit*y, brought back below m with at most two subtractions
	always_comb begin
		sum  = {1'b0, r_q, 1'b0} + (a_q[cnt_q] ? {2'b00, y_q} : '0);
		m1   = {2'b00, m_q};
		m2   = {1'b0, m_q, 1'b0};
		sub1 = sum - m1;
		sub2 = sum - m2;
		if (sum >= m2) begin
			r_step = sub2[N-1:0];
		end else if (sum >= m1) begin
			r_step = sub1[N-1:0];
		end else begin
			r_step = sum[N-1:0];
		end
	end

	assign operands.ready = (uw.op == OP_LOAD);
	assign result.valid   = out_valid_q;
	assign result.found   = out_found_q;

	always_comb begin
		flags.no_input  = !operands.valid;
		flags.small_mod = (m_q[N-1:1] == '0);
		flags.base_hit  = (a_q == b_q);
		flags.cnt_nz    = (cnt_q != '0);
		flags.k_end     = (k_q == m_q);
		flags.term_hit  = (r_q == b_q);
		flags.out_busy  = out_valid_q && !result.ready;
	end

	always_ff @(posedge clk) begin
		case (uw.op)
			OP_LOAD: begin
				m_q <= operands.modulus;
				a_q <= operands.base;
				b_q <= operands.target;
				k_q <= N'(2);
			end
			OP_MUL_INIT_ONE: begin
				y_q   <= N'(1);
				r_q   <= '0;
				cnt_q <= CNT_W'(N - 1);
			end
			OP_MUL_INIT_CUR: begin
				y_q   <= r_q;
				r_q   <= '0;
				cnt_q <= CNT_W'(N - 1);
			end
			OP_MUL_STEP: begin
				r_q   <= r_step;
				cnt_q <= cnt_q - 1'b1;
			end
			OP_INC_K: begin
				k_q <= k_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_found_q <= 1'b0;
		end else begin
			if (uw.op == OP_LOAD) begin
				found_q <= 1'b0;
			end else if (uw.op == OP_SET_FOUND) begin
				found_q <= 1'b1;
			end
			if (uw.op == OP_EMIT && !flags.out_busy) begin
				out_valid_q <= 1'b1;
				out_found_q <= found_q;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_rem_below_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(uw.op == OP_MUL_STEP) |-> (r_q < m_q))
		else $error("partial remainder not below modulus");

	a_mult_below_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(uw.op == OP_MUL_STEP) |-> (y_q < m_q))
		else $error("multiplicand not reduced");

	a_exp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(uw.op == OP_MUL_STEP) |-> (k_q <= m_q))
		else $error("exponent counter past modulus");

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(uw.op == OP_EMIT && !flags.out_busy) |=> (out_valid_q && out_found_q == $past(found_q)))
		else $error("result not loaded on emit");
`endif

endmodule
